// ===== rtl/core/icr_pkg.sv =====
// Shared types and constants for the integer constant recognizer.
package icr_pkg;

	localparam int SUFFIX_MAX = 3;
	localparam int SUFFIX_CW  = $clog2(SUFFIX_MAX + 1);

	// Token status codes
	typedef enum logic [1:0] {
		ST_POSSIBLE   = 2'd0,
		ST_MATCH      = 2'd1,
		ST_IMPOSSIBLE = 2'd2
	} status_t;

	// One character transaction on the input side
	typedef struct packed {
		logic       new_token;
		logic [7:0] char_code;
	} item_t;

	// One result transaction on the output side
	typedef struct packed {
		logic    in_suffix;
		status_t status;
	} result_t;

endpackage

// ===== rtl/core/icr_in_reg.sv =====
// Input register stage: holds one accepted character until the step logic takes it.
module icr_in_reg import icr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  valid_s1,
	input  logic  advance,
	output item_t item_s1
);

	// Take a new item whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/core/icr_step.sv =====
// Recognizer state and the combinational next-state and result logic.
module icr_step import icr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	output result_t result
);

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h37);
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic is_u(input logic [7:0] c);
		return (c == 8'h75) || (c == 8'h55);
	endfunction

	function automatic logic is_l(input logic [7:0] c);
		return (c == 8'h6c) || (c == 8'h4c);
	endfunction

	function automatic logic long_pair(input logic [7:0] a, input logic [7:0] b);
		return ((a == 8'h6c) && (b == 8'h6c)) || ((a == 8'h4c) && (b == 8'h4c));
	endfunction

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;

	// Stored state
	status_t              overall_q, dec_q, oct_q, hex_q;
	logic                 hex_first_q, hex_want_x_q, hex_want_dig_q;
	logic                 suf_mode_q;
	logic [SUFFIX_CW-1:0] suf_cnt_q;
	logic [7:0]           suf_chars_q [SUFFIX_MAX];

	// State after an optional new-token clear
	status_t              overall_c, dec_c, oct_c, hex_c;
	logic                 hex_first_c, hex_want_x_c, hex_want_dig_c;
	logic                 suf_mode_c;
	logic [SUFFIX_CW-1:0] suf_cnt_c;
	logic [7:0]           suf_chars_c [SUFFIX_MAX];

	// Next state
	status_t              overall_d, dec_d, oct_d, hex_d;
	logic                 hex_first_d, hex_want_x_d, hex_want_dig_d;
	logic                 suf_mode_d;
	logic [SUFFIX_CW-1:0] suf_cnt_d;
	logic                 suf_wr;
	logic [7:0]           suf_new [SUFFIX_MAX];
	logic                 suf_ok;
	logic [7:0]           c;

	assign c = item_s1.char_code;

	// Clear to the start-of-token state on a new token
	always_comb begin
		if (item_s1.new_token) begin
			overall_c      = ST_POSSIBLE;
			dec_c          = ST_POSSIBLE;
			oct_c          = ST_POSSIBLE;
			hex_c          = ST_POSSIBLE;
			hex_first_c    = 1'b1;
			hex_want_x_c   = 1'b0;
			hex_want_dig_c = 1'b0;
			suf_mode_c     = 1'b0;
			suf_cnt_c      = '0;
			for (int i = 0; i < SUFFIX_MAX; i++) begin
				suf_chars_c[i] = 8'h00;
			end
		end else begin
			overall_c      = overall_q;
			dec_c          = dec_q;
			oct_c          = oct_q;
			hex_c          = hex_q;
			hex_first_c    = hex_first_q;
			hex_want_x_c   = hex_want_x_q;
			hex_want_dig_c = hex_want_dig_q;
			suf_mode_c     = suf_mode_q;
			suf_cnt_c      = suf_cnt_q;
			for (int i = 0; i < SUFFIX_MAX; i++) begin
				suf_chars_c[i] = suf_chars_q[i];
			end
		end
	end

	// Place the character into the suffix buffer as it would be after writing
	always_comb begin
		for (int i = 0; i < SUFFIX_MAX; i++) begin
			suf_new[i] = (suf_cnt_c == SUFFIX_CW'(i)) ? c : suf_chars_c[i];
		end
		unique case (suf_cnt_c)
			SUFFIX_CW'(0): suf_ok = is_u(suf_new[0]) || is_l(suf_new[0]);
			SUFFIX_CW'(1): suf_ok = long_pair(suf_new[0], suf_new[1]) ||
				(is_u(suf_new[0]) && is_l(suf_new[1])) ||
				(is_l(suf_new[0]) && is_u(suf_new[1]));
			SUFFIX_CW'(2): suf_ok = (is_u(suf_new[0]) && long_pair(suf_new[1], suf_new[2])) ||
				(long_pair(suf_new[0], suf_new[1]) && is_u(suf_new[2]));
			default: suf_ok = 1'b0;
		endcase
	end

	// Step the three sub-recognizers, then the overall status and suffix
	always_comb begin
		dec_d          = dec_c;
		oct_d          = oct_c;
		hex_d          = hex_c;
		hex_first_d    = hex_first_c;
		hex_want_x_d   = hex_want_x_c;
		hex_want_dig_d = hex_want_dig_c;
		overall_d      = overall_c;
		suf_mode_d     = suf_mode_c;
		suf_cnt_d      = suf_cnt_c;
		suf_wr         = 1'b0;

		if (overall_c != ST_IMPOSSIBLE) begin
			// decimal: nonzero lead digit
			if (dec_c != ST_IMPOSSIBLE) begin
				if (((c == CH_ZERO) && (dec_c != ST_MATCH)) || !is_dec(c)) begin
					dec_d = ST_IMPOSSIBLE;
				end else begin
					dec_d = ST_MATCH;
				end
			end
			// octal: leading zero then octal digits
			if (oct_c != ST_IMPOSSIBLE) begin
				if (((c != CH_ZERO) && (oct_c != ST_MATCH)) || !is_oct(c)) begin
					oct_d = ST_IMPOSSIBLE;
				end else begin
					oct_d = ST_MATCH;
				end
			end
			// hex: zero, x, then hex digits
			if (hex_c != ST_IMPOSSIBLE) begin
				priority if (hex_first_c) begin
					if (c == CH_ZERO) begin
						hex_want_x_d = 1'b1;
					end else begin
						hex_d = ST_IMPOSSIBLE;
					end
					hex_first_d = 1'b0;
				end else if (hex_want_x_c) begin
					if ((c == CH_X_LO) || (c == CH_X_UP)) begin
						hex_want_dig_d = 1'b1;
						hex_want_x_d   = 1'b0;
					end else begin
						hex_d = ST_IMPOSSIBLE;
					end
				end else if (hex_want_dig_c) begin
					hex_d = is_hexd(c) ? ST_MATCH : ST_IMPOSSIBLE;
				end else begin
					hex_d = hex_c;
				end
			end

			// combine, or switch to suffix matching after a complete match
			if (!suf_mode_c) begin
				priority if ((dec_d == ST_MATCH) || (oct_d == ST_MATCH) || (hex_d == ST_MATCH)) begin
					overall_d = ST_MATCH;
				end else if ((dec_d == ST_POSSIBLE) || (oct_d == ST_POSSIBLE) ||
					(hex_d == ST_POSSIBLE)) begin
					overall_d = ST_POSSIBLE;
				end else if (overall_c == ST_MATCH) begin
					suf_mode_d = 1'b1;
				end else begin
					overall_d = ST_IMPOSSIBLE;
				end
			end

			if (suf_mode_d) begin
				if (suf_cnt_c >= SUFFIX_CW'(SUFFIX_MAX)) begin
					overall_d = ST_IMPOSSIBLE;
				end else begin
					suf_wr    = 1'b1;
					suf_cnt_d = suf_cnt_c + SUFFIX_CW'(1);
					overall_d = suf_ok ? ST_MATCH : ST_IMPOSSIBLE;
				end
			end
		end

		result.status    = overall_d;
		result.in_suffix = suf_mode_d;
	end

	// Commit the state when the item moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q      <= ST_POSSIBLE;
			dec_q          <= ST_POSSIBLE;
			oct_q          <= ST_POSSIBLE;
			hex_q          <= ST_POSSIBLE;
			hex_first_q    <= 1'b1;
			hex_want_x_q   <= 1'b0;
			hex_want_dig_q <= 1'b0;
			suf_mode_q     <= 1'b0;
			suf_cnt_q      <= '0;
			for (int i = 0; i < SUFFIX_MAX; i++) begin
				suf_chars_q[i] <= 8'h00;
			end
		end else if (advance) begin
			overall_q      <= overall_d;
			dec_q          <= dec_d;
			oct_q          <= oct_d;
			hex_q          <= hex_d;
			hex_first_q    <= hex_first_d;
			hex_want_x_q   <= hex_want_x_d;
			hex_want_dig_q <= hex_want_dig_d;
			suf_mode_q     <= suf_mode_d;
			suf_cnt_q      <= suf_cnt_d;
			for (int i = 0; i < SUFFIX_MAX; i++) begin
				if (suf_wr) begin
					suf_chars_q[i] <= suf_new[i];
				end else begin
					suf_chars_q[i] <= suf_chars_c[i];
				end
			end
		end
	end

endmodule

// ===== rtl/core/icr_out_reg.sv =====
// Output register stage: holds a result until the receiver takes it.
module icr_out_reg import icr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t result,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_s2
);

	// Advance when a character is held and the register is empty or being drained
	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== rtl/core/integer_constant_recognizer_unit.sv =====
// Top level of the C integer constant recognizer.
//
// Usage:
//   Input channel s_*: one character transaction per cycle while s_tready is
//   high. s_tdata carries the ASCII byte; s_tuser set clears the recognizer
//   before that character, starting a new token.
//   Output channel m_*: one result per character. m_tdata[1:0] is the token
//   status (0 possible prefix, 1 complete match, 2 impossible); m_tuser is
//   high once the token is in its u/l/ll suffix.
//   Path: an accepted character waits in the input register; its result is
//   registered in the output register, which takes it while m_* is not stalled.
//   Throughput: one character per cycle when the receiver is not stalling, set
//   by the combinational state update between the input and output registers.
//   Stall: with m_tready low the result holds, the input register keeps one
//   more character, and s_tready then drops; nothing is lost or repeated.
//   Reset: arst_n clears both valid flags and puts the recognizer in the
//   start-of-token state, so the first token needs no s_tuser.
module integer_constant_recognizer_unit import icr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] new_token
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [1:0] status, [7:2] zero
	output logic       m_tuser    // [0] in_suffix
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t result_s2;

	assign in_item.char_code = s_tdata;
	assign in_item.new_token = s_tuser;

	icr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	icr_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	icr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_s2 (result_s2)
	);

	// Pack the result transaction
	assign m_tdata = {6'b0, result_s2.status};
	assign m_tuser = result_s2.in_suffix;

endmodule
